[rtl/bdeq_pkg.sv]
package bdeq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // stream payload layout
  localparam int IN_TDATA_W  = 40;
  localparam int IN_PAD_W    = IN_TDATA_W - CMD_W - VAL_W;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + VAL_W + VAL_W + 1 + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PEEK       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_REAR  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_REAR   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic rd;
    logic load;
  } ctrl_cmd_t;

endpackage

[rtl/bounded_double_ended_queue.sv]
// An accepted item passes through the execute, RAM read and load states before its
// result is valid; load waits while the output register holds an untaken result.
// A new item is accepted only once the previous one has been loaded to the output.
// An item may be accepted while the previous result waits in the output register.
// Reset (rst_n low, synchronous): queue emptied, front index 0, capacity 16;
// storage contents are not cleared.
module bounded_double_ended_queue
  import bdeq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // command[2:0], value[34:3], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ok[0], front_value[32:1],
                                             // rear_value[64:33], empty_flag[65],
                                             // full_flag[66], zero pad
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data
);

  ctrl_cmd_t cmd;

  bdeq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bdeq_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );

endmodule

[rtl/bdeq_ram.sv]
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bdeq_ctrl.sv]
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new result
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: cmd.latch_in = in_tvalid;
      ST_EXEC: cmd.exec     = 1'b1;
      ST_READ: cmd.rd       = 1'b1;
      ST_LOAD: cmd.load     = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_load_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending item");

  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_EXEC && !in_tready))
    else $error("accepted item not executed next");

  a_read_then_load : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> (state_r == ST_LOAD))
    else $error("read not followed by load");

  a_cmd_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

endmodule

[rtl/bdeq_dp.sv]
module bdeq_dp
  import bdeq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    cfg_wr_en,
  input  logic [CAP_W-1:0]        cfg_wr_data,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  cmd_t                   cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [AW-1:0]          front_r, front_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic                   ok_r, ok_nxt;

  logic                   res_ok_r, res_empty_r, res_full_r;
  logic [VAL_W-1:0]       res_front_r, res_rear_r;

  logic [EW-1:0]          cap_ext, eff_cap;
  logic                   full;
  logic [AW-1:0]          front_dec, front_inc, rear_push_addr, rear_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic [DATA_WIDTH-1:0]  front_data, rear_data;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  // capacity zero acts as one, above the storage depth saturates
  assign cap_ext = EW'(cap_r);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end
  end

  assign full = EW'(cnt_r) >= eff_cap;

  assign front_dec      = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc      = wrap_idx(SW'(front_r) + SW'(1));
  assign rear_push_addr = wrap_idx(SW'(front_r) + SW'(cnt_r));
  assign rear_addr      = (cnt_r == '0) ? front_r
                          : wrap_idx(SW'(front_r) + SW'(cnt_r) - SW'(1));

  assign wr_data = DATA_WIDTH'(val_r);

  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = rear_push_addr;
    unique case (cmd_r)
      CMD_PEEK: ok_nxt = 1'b1;
      CMD_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (!full) begin
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + CNT_W'(1);
          wr_en     = cmd.exec;
          ok_nxt    = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (!full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          wr_en   = cmd.exec;
          ok_nxt  = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (cnt_r != '0) begin
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          ok_nxt  = 1'b1;
        end
      end
      default: ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        front_r <= front_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= cmd_t'(in_tdata[CMD_W-1:0]);
      val_r <= in_tdata[CMD_W +: VAL_W];
    end
    if (cmd.exec) begin
      ok_r <= ok_nxt;
    end
    if (cmd.load) begin
      res_ok_r    <= ok_r;
      res_empty_r <= (cnt_r == '0);
      res_full_r  <= full;
      res_front_r <= (cnt_r == '0) ? '1 : VAL_W'(front_data);
      res_rear_r  <= (cnt_r == '0) ? '1 : VAL_W'(rear_data);
    end
  end

  // two copies of the storage, one read port each for front and rear
  bdeq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_front (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (front_r),
    .rd_data (front_data)
  );

  bdeq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_rear (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (rear_addr),
    .rd_data (rear_data)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_full_r, res_empty_r,
                      res_rear_r, res_front_r, res_ok_r};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (cmd_r == CMD_PUSH_FRONT || cmd_r == CMD_PUSH_REAR) && ok_nxt
      |=> (EW'(cnt_r) <= eff_cap))
    else $error("push took count past capacity");

  a_empty_pop_fails : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && cnt_r == '0 && (cmd_r == CMD_POP_FRONT || cmd_r == CMD_POP_REAR)
      |=> !ok_r && cnt_r == '0)
    else $error("pop on empty queue reported success");

  a_state_held : assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.exec) |-> $stable(cnt_r) && $stable(front_r))
    else $error("index or count moved outside execute");

endmodule

[tb/bounded_double_ended_queue_tb.sv]
`timescale 1ns / 1ps

module bounded_double_ended_queue_tb
  import bdeq_pkg::*;
();

  localparam int QUEUE_DEPTH  = DEPTH_DEF;
  localparam int SLOT_W       = $clog2(QUEUE_DEPTH);
  localparam int PHASE_COUNT  = 26;
  localparam int PHASE_ITEMS  = 75;
  localparam int MAX_GAP      = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 3000;

  // command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

  localparam logic [VAL_W-1:0] EMPTY_WORD = '1;
  localparam logic [VAL_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] WORD_MIN   = 32'h8000_0000;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] front;
    logic [VAL_W-1:0] rear;
    logic             empty;
    logic             full;
  } deque_status_t;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] capacity;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    bit               typed;
    deque_status_t    want;
  } stim_row_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  // predicted queue contents and settings
  logic [VAL_W-1:0] model_slots [QUEUE_DEPTH];
  int               model_head     = 0;
  int               model_count    = 0;
  logic [CAP_W-1:0] model_capacity = CAP_RESET;

  deque_status_t awaited_results [$];
  int            error_count   = 0;
  int            results_taken = 0;
  bit            rx_holding    = 1'b0;
  int            tx_max_gap    = MAX_GAP;
  int            rx_max_gap    = MAX_GAP;

  bounded_double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic int usable_capacity();
    int c;
    c = int'(model_capacity);
    if (c == 0) return 1;
    if (c > QUEUE_DEPTH) return QUEUE_DEPTH;
    return c;
  endfunction

  function automatic deque_status_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [VAL_W-1:0] value);
    deque_status_t st;
    bit            was_full;
    was_full = model_count >= usable_capacity();
    st       = '0;
    case (cmd)
      CMD_PEEK: begin
        st.ok = 1'b1;
      end
      CMD_PUSH_FRONT: begin
        if (!was_full) begin
          model_head = (model_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          model_slots[SLOT_W'(model_head)] = value;
          model_count++;
          st.ok = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (!was_full) begin
          model_slots[SLOT_W'((model_head + model_count) % QUEUE_DEPTH)] = value;
          model_count++;
          st.ok = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (model_count != 0) begin
          model_head = (model_head + 1) % QUEUE_DEPTH;
          model_count--;
          st.ok = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (model_count != 0) begin
          model_count--;
          st.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (model_count == 0) begin
      st.front = EMPTY_WORD;
      st.rear  = EMPTY_WORD;
      st.empty = 1'b1;
    end else begin
      st.front = model_slots[SLOT_W'(model_head)];
      st.rear  = model_slots[SLOT_W'((model_head + model_count - 1) % QUEUE_DEPTH)];
      st.empty = 1'b0;
    end
    // a lowered capacity leaves the queue over-full until enough pops
    st.full = model_count >= usable_capacity();
    return st;
  endfunction

  function automatic stim_row_t op_row(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
    stim_row_t r;
    r.is_cfg   = 1'b0;
    r.capacity = '0;
    r.cmd      = cmd;
    r.value    = value;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                                          deque_status_t want);
    stim_row_t r;
    r       = op_row(cmd, value);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cap_row(logic [CAP_W-1:0] cap);
    stim_row_t r;
    r          = op_row(CMD_PEEK, '0);
    r.is_cfg   = 1'b1;
    r.capacity = cap;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // offer one item; valid stays high afterwards unless the next item idles first
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value, bit typed,
                           deque_status_t want);
    int            gap;
    deque_status_t predicted;
    gap = rx_holding ? 0 : $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, value, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_command(cmd, value);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // hold input until every result is back, then write the register
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    model_capacity = cap;
  endtask

  initial begin
    stim_row_t        rows [$];
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    logic [CAP_W-1:0] cap;
    int               pick;
    int               push_pct;

    rows.push_back(known_row(CMD_PEEK, '0, '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}));
    rows.push_back(known_row(CMD_POP_FRONT, '0, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}));
    rows.push_back(known_row(CMD_POP_REAR, '0, '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}));
    rows.push_back(known_row(CMD_RSVD_LO, 32'h1234_5678,
                             '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}));
    rows.push_back(known_row(CMD_RSVD_HI, EMPTY_WORD,
                             '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0}));
    rows.push_back(known_row(CMD_PUSH_REAR, WORD_MAX, '{1'b1, WORD_MAX, WORD_MAX, 1'b0, 1'b0}));
    rows.push_back(known_row(CMD_PUSH_FRONT, WORD_MIN, '{1'b1, WORD_MIN, WORD_MAX, 1'b0, 1'b0}));
    rows.push_back(op_row(CMD_PUSH_REAR, EMPTY_WORD));
    rows.push_back(op_row(CMD_PUSH_FRONT, '0));
    rows.push_back(op_row(CMD_RSVD_MID, 32'hDEAD_BEEF));
    rows.push_back(op_row(CMD_PEEK, 32'hFFFF_0000));
    // capacity zero acts as one, and sits below the four entries held
    rows.push_back(cap_row(5'd0));
    rows.push_back(op_row(CMD_PUSH_REAR, 32'h5A5A_A5A5));
    rows.push_back(op_row(CMD_PUSH_FRONT, 32'hA5A5_5A5A));
    rows.push_back(op_row(CMD_POP_REAR, '0));
    rows.push_back(op_row(CMD_POP_FRONT, '0));
    rows.push_back(op_row(CMD_POP_REAR, '0));
    rows.push_back(op_row(CMD_POP_FRONT, '0));
    rows.push_back(op_row(CMD_PUSH_FRONT, 32'h0000_0001));
    rows.push_back(op_row(CMD_PUSH_FRONT, 32'h0000_0002));
    // capacities above the storage depth saturate
    rows.push_back(cap_row(5'd31));
    rows.push_back(op_row(CMD_PUSH_REAR, 32'h0000_0003));
    rows.push_back(cap_row(5'd17));
    rows.push_back(op_row(CMD_POP_FRONT, '0));
    rows.push_back(op_row(CMD_POP_REAR, '0));
    rows.push_back(cap_row(5'd16));
    rows.push_back(op_row(CMD_POP_FRONT, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_capacity(rows[i].capacity);
      end else begin
        send_item(rows[i].cmd, rows[i].value, rows[i].typed, rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd0;
        3: cap = 5'd31;
        default: cap = CAP_W'($urandom_range(0, 1) ? $urandom_range(1, QUEUE_DEPTH)
                                                   : $urandom_range(0, 31));
      endcase
      write_capacity(cap);
      tx_max_gap = (phase % 4 == 2) ? 0 : MAX_GAP;
      rx_max_gap = (phase % 3 == 1) ? 0 : MAX_GAP;
      // alternate filling, draining and balanced traffic
      case (phase % 3)
        0: push_pct = 65;
        1: push_pct = 25;
        default: push_pct = 45;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else if (pick < 10) begin
          cmd = CMD_PEEK;
        end else if (pick < 10 + push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
        end
        case ($urandom_range(0, 7))
          0: value = WORD_MIN;
          1: value = WORD_MAX;
          2: value = EMPTY_WORD;
          default: value = $urandom;
        endcase
        send_item(cmd, value, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int            gap;
    deque_status_t got;
    deque_status_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      // twice in the run, starve the output so the block backs up
      if (results_taken == 200 || results_taken == 1300) begin
        rx_holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.ok    = out_tdata[0];
      got.front = out_tdata[VAL_W:1];
      got.rear  = out_tdata[2*VAL_W:VAL_W+1];
      got.empty = out_tdata[2*VAL_W+1];
      got.full  = out_tdata[2*VAL_W+2];
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no item pending", results_taken));
      end else begin
        want = awaited_results.pop_front();
        if (got.ok !== want.ok)
          flag_mismatch($sformatf("result %0d ok %b, want %b",
                                  results_taken, got.ok, want.ok));
        if (got.front !== want.front)
          flag_mismatch($sformatf("result %0d front_value %h, want %h",
                                  results_taken, got.front, want.front));
        if (got.rear !== want.rear)
          flag_mismatch($sformatf("result %0d rear_value %h, want %h",
                                  results_taken, got.rear, want.rear));
        if (got.empty !== want.empty)
          flag_mismatch($sformatf("result %0d empty_flag %b, want %b",
                                  results_taken, got.empty, want.empty));
        if (got.full !== want.full)
          flag_mismatch($sformatf("result %0d full_flag %b, want %b",
                                  results_taken, got.full, want.full));
      end
      results_taken++;
    end
  end

  // stop when neither side has moved an item for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/bdeq_pkg.sv
rtl/bdeq_ram.sv
rtl/bdeq_ctrl.sv
rtl/bdeq_dp.sv
rtl/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_tb.sv
